// File: src/swhc_pkg.sv
// ----------------------------------------------------------------------------
// swhc_pkg
// Shared constants, types and command codes for the sliding window hit
// counter: bucket ring geometry, field widths and the bucket entry layout.
// ----------------------------------------------------------------------------
package swhc_pkg;

  // ring geometry
  localparam int WINDOW = 300;
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // field widths
  localparam int CMD_W   = 2;
  localparam int STAMP_W = 32;
  localparam int CNT_W   = 16;
  localparam int TOTAL_W = 25;
  localparam int LOAD_W  = 24;
  localparam int ENTRY_W = STAMP_W + 2 * CNT_W;

  // scan accumulator, wide enough for every bucket at full count
  localparam int ACC_W = (CNT_W + SLOT_W + 1 > TOTAL_W) ? CNT_W + SLOT_W + 1 : TOTAL_W + 1;

  // saturation limits
  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic [LOAD_W-1:0]  LOAD_MAX  = '1;

  // slot reduction: quotient estimate by reciprocal, then up to two corrections
  localparam int          RECIP_SH = 31 + $clog2(WINDOW);
  localparam logic [31:0] RECIP    = 32'((64'd1 << RECIP_SH) / WINDOW);
  localparam int          RED_W    = SLOT_W + 2;

  // average divide: total with 8 fractional bits, divided by the window,
  // using the same reciprocal with the 8-bit scaling folded into the shift
  localparam int DIVIDEND_W = TOTAL_W + 8;
  localparam int LOAD_SH    = RECIP_SH - 8;

  // commands
  typedef enum logic [CMD_W-1:0] {
    CMD_PUT      = 2'd0,
    CMD_GET      = 2'd1,
    CMD_MEAS_PUT = 2'd2,
    CMD_MEAS_GET = 2'd3
  } cmd_t;

  // one bucket of the ring
  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [CNT_W-1:0]   puts;
    logic [CNT_W-1:0]   gets;
  } entry_t;

  // slot reducer result
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
  } slot_res_t;

endpackage

// File: src/swhc_ram.sv
// ----------------------------------------------------------------------------
// swhc_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module swhc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/swhc_slot.sv
// ----------------------------------------------------------------------------
// swhc_slot
// Two-stage reducer that maps a timestamp to its ring slot, now_sec mod
// WINDOW: a reciprocal multiply estimates the quotient, then the remainder
// is fixed up with at most two compare-and-subtract steps.
// ----------------------------------------------------------------------------
module swhc_slot (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [swhc_pkg::STAMP_W-1:0]      now_sec,
  output swhc_pkg::slot_res_t               res
);

  logic [63:0]                     prod;
  logic                            prod_v;
  logic [swhc_pkg::STAMP_W-1:0]    now_q;
  logic [31:0]                     quo;
  logic [swhc_pkg::RED_W-1:0]      quo_w;
  logic [swhc_pkg::RED_W-1:0]      win_w;
  logic [swhc_pkg::RED_W-1:0]      rem0;
  logic [swhc_pkg::RED_W-1:0]      rem1;
  logic [swhc_pkg::RED_W-1:0]      rem2;

  // stage 1: quotient estimate product
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v <= 1'b0;
    end else begin
      prod_v <= start;
    end
    prod  <= now_sec * swhc_pkg::RECIP;
    now_q <= now_sec;
  end

  // stage 2: remainder from low bits only, then correction
  always_comb begin
    quo   = 32'(prod >> swhc_pkg::RECIP_SH);
    win_w = swhc_pkg::RED_W'(swhc_pkg::WINDOW);
    quo_w = quo[swhc_pkg::RED_W-1:0] * win_w;
    rem0  = now_q[swhc_pkg::RED_W-1:0] - quo_w;
    rem1  = (rem0 >= win_w) ? rem0 - win_w : rem0;
    rem2  = (rem1 >= win_w) ? rem1 - win_w : rem1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= prod_v;
    end
    res.slot <= rem2[swhc_pkg::SLOT_W-1:0];
  end

  // checks
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.slot < swhc_pkg::SLOT_W'(swhc_pkg::WINDOW - 1) ||
                   res.slot == swhc_pkg::SLOT_W'(swhc_pkg::WINDOW - 1)))
    else $error("slot out of ring range");

  a_slot_latency: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> $past(start, 2))
    else $error("slot result without a start two cycles earlier");

endmodule

// File: src/swhc_div.sv
// ----------------------------------------------------------------------------
// swhc_div
// Two-stage divide of total * 256 by the constant WINDOW: a reciprocal
// multiply estimates the quotient, then the remainder is checked with at
// most two compare-and-subtract steps. done is registered from start through prod_v.
// ----------------------------------------------------------------------------
module swhc_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [swhc_pkg::TOTAL_W-1:0]        total,
  output logic                                done,
  output logic [swhc_pkg::DIVIDEND_W-1:0]     quotient
);

  logic [63:0]                         prod;
  logic                                prod_v;
  logic [swhc_pkg::DIVIDEND_W-1:0]     scaled;
  logic [swhc_pkg::RED_W-1:0]          low_q;
  logic [swhc_pkg::DIVIDEND_W-1:0]     quo0;
  logic [swhc_pkg::DIVIDEND_W-1:0]     quo1;
  logic [swhc_pkg::DIVIDEND_W-1:0]     quo2;
  logic [swhc_pkg::RED_W-1:0]          win_w;
  logic [swhc_pkg::RED_W-1:0]          quo_w;
  logic [swhc_pkg::RED_W-1:0]          rem0;
  logic [swhc_pkg::RED_W-1:0]          rem1;

  // dividend low bits for the remainder check
  assign scaled = {total, 8'd0};

  // stage 1: quotient estimate product
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v <= 1'b0;
    end else begin
      prod_v <= start;
    end
    prod  <= total * swhc_pkg::RECIP;
    low_q <= scaled[swhc_pkg::RED_W-1:0];
  end

  // stage 2: remainder from low bits only, then correction
  always_comb begin
    quo0  = swhc_pkg::DIVIDEND_W'(prod >> swhc_pkg::LOAD_SH);
    win_w = swhc_pkg::RED_W'(swhc_pkg::WINDOW);
    quo_w = quo0[swhc_pkg::RED_W-1:0] * win_w;
    rem0  = low_q - quo_w;
    if (rem0 >= win_w) begin
      rem1 = rem0 - win_w;
      quo1 = quo0 + 1'b1;
    end else begin
      rem1 = rem0;
      quo1 = quo0;
    end
    quo2 = (rem1 >= win_w) ? quo1 + 1'b1 : quo1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= prod_v;
    end
    quotient <= quo2;
  end

endmodule

// File: src/sliding_window_hit_counter_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_hit_counter_unit
// Counts put and get events in a ring of per-second buckets and measures the
// put or get load over the window.
// ----------------------------------------------------------------------------
// Usage:
// - input channel in_valid/in_ready carries cmd and now_sec; output channel
//   out_valid/out_ready carries window_total and load_avg_q8, one result beat
//   per input beat, in order.
// - put/get events do one read-modify-write of the bucket at now_sec mod
//   WINDOW: slot reduction, the read, the write back, then the output
//   register; a new item is taken only once this result is in the output
//   register.
// - measure commands walk all WINDOW buckets through the single read port,
//   one per cycle, then a two-stage reciprocal divide gives the average.
// - one item is in flight at a time; in_ready is high whenever the unit is
//   not busy with an item or with the clearing pass.
// - the result sits in an output register, so a new item is taken while a
//   result waits; if the receiver still stalls when the next result is done,
//   the unit holds that result and takes no further input.
// - after reset a clearing pass writes every bucket to zero, with in_ready low.
// ----------------------------------------------------------------------------
module sliding_window_hit_counter_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [swhc_pkg::CMD_W-1:0]        cmd,
  input  logic [swhc_pkg::STAMP_W-1:0]      now_sec,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [swhc_pkg::TOTAL_W-1:0]      window_total,
  output logic [swhc_pkg::LOAD_W-1:0]       load_avg_q8
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SLOT,
    ST_MODIFY,
    ST_SCAN,
    ST_SUM,
    ST_LOAD,
    ST_DIV,
    ST_RESP
  } state_t;

  state_t                              state;
  swhc_pkg::cmd_t                      cmd_q;
  logic [swhc_pkg::STAMP_W-1:0]        now_q;
  logic [swhc_pkg::SLOT_W-1:0]         k;
  logic [swhc_pkg::SLOT_W-1:0]         slot_q;
  logic                                scan_pend;
  logic [swhc_pkg::ACC_W-1:0]          acc;
  logic [swhc_pkg::TOTAL_W-1:0]        res_total;
  logic [swhc_pkg::LOAD_W-1:0]         res_load;

  logic                                accept;
  logic                                is_event;
  swhc_pkg::slot_res_t                 slot_res;
  logic                                mem_we;
  logic                                mem_re;
  logic [swhc_pkg::SLOT_W-1:0]         mem_wr_addr;
  logic [swhc_pkg::SLOT_W-1:0]         mem_rd_addr;
  logic [swhc_pkg::ENTRY_W-1:0]        mem_wr_data;
  logic [swhc_pkg::ENTRY_W-1:0]        mem_rd_data;
  swhc_pkg::entry_t                    ent_rd;
  swhc_pkg::entry_t                    ent_mod;
  logic signed [swhc_pkg::STAMP_W:0]   age;
  logic                                in_win;
  logic [swhc_pkg::CNT_W-1:0]          scan_cnt;
  logic [swhc_pkg::TOTAL_W-1:0]        total_sat;
  logic                                div_start;
  logic                                div_done;
  logic [swhc_pkg::DIVIDEND_W-1:0]     div_quo;
  logic [swhc_pkg::LOAD_W-1:0]         load_sat;
  logic                                k_last;

  // handshake
  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign is_event = (swhc_pkg::cmd_t'(cmd) == swhc_pkg::CMD_PUT) ||
                    (swhc_pkg::cmd_t'(cmd) == swhc_pkg::CMD_GET);
  assign k_last   = (k == swhc_pkg::SLOT_W'(swhc_pkg::WINDOW - 1));

  // slot reducer
  swhc_slot u_slot (
    .clk     (clk),
    .rst     (rst),
    .start   (accept && is_event),
    .now_sec (now_sec),
    .res     (slot_res)
  );

  // bucket store
  swhc_ram #(
    .WIDTH (swhc_pkg::ENTRY_W),
    .DEPTH (swhc_pkg::WINDOW)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .re      (mem_re),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // bucket update: restamp a stale bucket, then saturating increment
  always_comb begin
    ent_rd  = swhc_pkg::entry_t'(mem_rd_data);
    ent_mod = ent_rd;
    if (ent_rd.stamp != now_q) begin
      ent_mod.stamp = now_q;
      ent_mod.puts  = '0;
      ent_mod.gets  = '0;
    end
    if (cmd_q == swhc_pkg::CMD_PUT) begin
      if (ent_mod.puts != swhc_pkg::CNT_MAX) begin
        ent_mod.puts = ent_mod.puts + 1'b1;
      end
    end else begin
      if (ent_mod.gets != swhc_pkg::CNT_MAX) begin
        ent_mod.gets = ent_mod.gets + 1'b1;
      end
    end
  end

  // memory port steering
  always_comb begin
    mem_re      = (state == ST_SCAN) || (state == ST_SLOT && slot_res.valid);
    mem_rd_addr = (state == ST_SCAN) ? k : slot_res.slot;
    mem_we      = (state == ST_CLEAR) || (state == ST_MODIFY);
    mem_wr_addr = (state == ST_CLEAR) ? k : slot_q;
    mem_wr_data = (state == ST_CLEAR) ? '0 : ent_mod;
  end

  // window test on scanned bucket: signed age below the window
  always_comb begin
    age      = $signed({1'b0, now_q}) - $signed({1'b0, ent_rd.stamp});
    in_win   = (age < $signed((swhc_pkg::STAMP_W + 1)'(swhc_pkg::WINDOW)));
    scan_cnt = (cmd_q == swhc_pkg::CMD_MEAS_PUT) ? ent_rd.puts : ent_rd.gets;
  end

  // total and average saturation
  always_comb begin
    total_sat = (acc > swhc_pkg::ACC_W'(swhc_pkg::TOTAL_MAX)) ?
                swhc_pkg::TOTAL_MAX : acc[swhc_pkg::TOTAL_W-1:0];
    load_sat  = (div_quo > swhc_pkg::DIVIDEND_W'(swhc_pkg::LOAD_MAX)) ?
                swhc_pkg::LOAD_MAX : div_quo[swhc_pkg::LOAD_W-1:0];
    div_start = (state == ST_LOAD);
  end

  // average divider
  swhc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .total    (total_sat),
    .done     (div_done),
    .quotient (div_quo)
  );

  // control sequence and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      k         <= '0;
      scan_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      scan_pend <= (state == ST_SCAN);
      if (scan_pend) begin
        acc <= acc + (in_win ? swhc_pkg::ACC_W'(scan_cnt) : '0);
      end
      case (state)
        ST_CLEAR: begin
          k <= k + 1'b1;
          if (k_last) begin
            k     <= '0;
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cmd_q <= swhc_pkg::cmd_t'(cmd);
            now_q <= now_sec;
            if (is_event) begin
              state <= ST_SLOT;
            end else begin
              acc   <= '0;
              k     <= '0;
              state <= ST_SCAN;
            end
          end
        end
        ST_SLOT: begin
          if (slot_res.valid) begin
            slot_q <= slot_res.slot;
            state  <= ST_MODIFY;
          end
        end
        ST_MODIFY: begin
          res_total <= '0;
          res_load  <= '0;
          state     <= ST_RESP;
        end
        ST_SCAN: begin
          k <= k + 1'b1;
          if (k_last) begin
            k     <= '0;
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          res_total <= total_sat;
          state     <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            res_load <= load_sat;
            state    <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            window_total <= res_total;
            load_avg_q8  <= res_load;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  a_port_conflict: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("bucket read and write in the same cycle");

  a_modify_after_read: assert property (@(posedge clk) disable iff (rst)
    state == ST_MODIFY |-> $past(mem_re))
    else $error("bucket write back without a preceding read");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN || state == ST_DIV || state == ST_CLEAR) |-> !accept)
    else $error("item accepted while another is in progress");

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sliding window hit counter. A predictor keeps
// its own bucket ring and works out the total and Q8 load for every accepted
// beat. Results are compared in order. Directed edge cases run first, then
// a pile of hits on one bucket, receiver back-pressure and random traffic,
// with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          CYCLE_LIMIT = 6_000_000;
  localparam int          DRAIN_WAIT  = 400;
  localparam logic [31:0] PILE_SEC    = 32'd4_000_123;

  typedef struct packed {
    logic [swhc_pkg::TOTAL_W-1:0] total;
    logic [swhc_pkg::LOAD_W-1:0]  avg_q8;
  } load_result_t;

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_ready;
  logic [swhc_pkg::CMD_W-1:0]     cmd;
  logic [swhc_pkg::STAMP_W-1:0]   now_sec;
  logic                           out_valid;
  logic                           out_ready;
  logic [swhc_pkg::TOTAL_W-1:0]   window_total;
  logic [swhc_pkg::LOAD_W-1:0]    load_avg_q8;

  // predictor copy of the bucket ring
  logic [swhc_pkg::STAMP_W-1:0]   ring_stamp [swhc_pkg::WINDOW];
  logic [swhc_pkg::CNT_W-1:0]     ring_puts  [swhc_pkg::WINDOW];
  logic [swhc_pkg::CNT_W-1:0]     ring_gets  [swhc_pkg::WINDOW];

  load_result_t         owed_results [$];

  bit                   tx_stall_en;
  bit                   rx_stall_en;
  int                   rx_hold_req;
  int                   errors;
  int                   n_events;
  int                   n_measures;
  int                   n_checked;
  int                   n_clamped;
  int                   cycle_count;

  sliding_window_hit_counter_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .now_sec      (now_sec),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .window_total (window_total),
    .load_avg_q8  (load_avg_q8)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // bucket ring update for events, window sum for measures
  function automatic load_result_t apply_item(swhc_pkg::cmd_t c,
                                              logic [swhc_pkg::STAMP_W-1:0] t);
    load_result_t r;
    int unsigned  slot;
    longint       age;
    logic [63:0]  sum;
    logic [63:0]  q8;
    r = '0;
    if (c == swhc_pkg::CMD_PUT || c == swhc_pkg::CMD_GET) begin
      slot = t % swhc_pkg::WINDOW;
      // stale bucket gets restamped and emptied
      if (ring_stamp[slot] != t) begin
        ring_stamp[slot] = t;
        ring_puts[slot]  = '0;
        ring_gets[slot]  = '0;
      end
      if (c == swhc_pkg::CMD_PUT) begin
        if (ring_puts[slot] != swhc_pkg::CNT_MAX) ring_puts[slot] = ring_puts[slot] + 1'b1;
        else n_clamped++;
      end else begin
        if (ring_gets[slot] != swhc_pkg::CNT_MAX) ring_gets[slot] = ring_gets[slot] + 1'b1;
        else n_clamped++;
      end
    end else begin
      sum = '0;
      // signed age, so stamps ahead of the query count too
      for (int k = 0; k < swhc_pkg::WINDOW; k++) begin
        age = longint'({32'd0, t}) - longint'({32'd0, ring_stamp[k]});
        if (age < swhc_pkg::WINDOW) begin
          if (c == swhc_pkg::CMD_MEAS_PUT) sum = sum + ring_puts[k];
          else sum = sum + ring_gets[k];
        end
      end
      if (sum > swhc_pkg::TOTAL_MAX) sum = swhc_pkg::TOTAL_MAX;
      q8 = (sum * 256) / swhc_pkg::WINDOW;
      r.total  = sum[swhc_pkg::TOTAL_W-1:0];
      r.avg_q8 = (q8 > swhc_pkg::LOAD_MAX) ? swhc_pkg::LOAD_MAX : q8[swhc_pkg::LOAD_W-1:0];
    end
    return r;
  endfunction

  // drive one input beat and hold it until accepted
  task automatic offer_beat(swhc_pkg::cmd_t c, logic [swhc_pkg::STAMP_W-1:0] t);
    int gap;
    gap = tx_stall_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    now_sec  <= t;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  // receiver: random stalls, plus long hold-off on request
  initial begin
    int g;
    out_ready <= 1'b0;
    forever begin
      if (rx_hold_req > 0) begin
        g = rx_hold_req;
        rx_hold_req = 0;
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end else begin
        g = rx_stall_en ? pick_gap() : 0;
        if (g > 0) begin
          out_ready <= 1'b0;
          repeat (g) @(posedge clk);
        end else begin
          out_ready <= 1'b1;
          @(posedge clk);
        end
      end
    end
  end

  // predict on input beats, check on output beats
  always @(posedge clk) begin
    load_result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        owed_results.push_back(apply_item(swhc_pkg::cmd_t'(cmd), now_sec));
        if (swhc_pkg::cmd_t'(cmd) == swhc_pkg::CMD_PUT ||
            swhc_pkg::cmd_t'(cmd) == swhc_pkg::CMD_GET) n_events++;
        else n_measures++;
      end
      if (out_valid && out_ready) begin
        n_checked++;
        if (owed_results.size() == 0) begin
          if (errors < 10)
            $display("unexpected result beat: total %0d load %0d", window_total,
                     load_avg_q8);
          errors++;
        end else begin
          want = owed_results.pop_front();
          if (want.total !== window_total || want.avg_q8 !== load_avg_q8) begin
            if (errors < 10)
              $display("mismatch at result %0d: total exp %0d got %0d, load exp %0d got %0d",
                       n_checked, want.total, window_total, want.avg_q8, load_avg_q8);
            errors++;
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               owed_results.size());
      $display("tb_top failed");
      $finish;
    end
  end

  // window edges, empty ring, extreme seconds, future stamps
  task automatic test_directed_edges();
    offer_beat(swhc_pkg::CMD_MEAS_PUT, 32'd0);
    offer_beat(swhc_pkg::CMD_MEAS_GET, 32'hFFFF_FFFF);
    offer_beat(swhc_pkg::CMD_PUT,      32'd0);
    offer_beat(swhc_pkg::CMD_GET,      32'd0);
    offer_beat(swhc_pkg::CMD_PUT,      32'd299);
    offer_beat(swhc_pkg::CMD_MEAS_PUT, 32'd299);
    offer_beat(swhc_pkg::CMD_MEAS_PUT, 32'd300);
    offer_beat(swhc_pkg::CMD_PUT,      32'd300);
    offer_beat(swhc_pkg::CMD_MEAS_GET, 32'd300);
    offer_beat(swhc_pkg::CMD_PUT,      32'd1000);
    offer_beat(swhc_pkg::CMD_MEAS_PUT, 32'd1299);
    offer_beat(swhc_pkg::CMD_MEAS_PUT, 32'd1300);
    offer_beat(swhc_pkg::CMD_PUT,      32'hFFFF_FFFF);
    offer_beat(swhc_pkg::CMD_GET,      32'hFFFF_FFFF);
    offer_beat(swhc_pkg::CMD_MEAS_PUT, 32'hFFFF_FFFF);
    offer_beat(swhc_pkg::CMD_MEAS_PUT, 32'd5);
    offer_beat(swhc_pkg::CMD_MEAS_GET, 32'h7FFF_FFFF);
    offer_beat(swhc_pkg::CMD_GET,      32'hAAAA_AAAA);
    offer_beat(swhc_pkg::CMD_PUT,      32'h5555_5555);
    offer_beat(swhc_pkg::CMD_MEAS_GET, 32'hAAAA_AAAA);
    offer_beat(swhc_pkg::CMD_MEAS_PUT, 32'h5555_5555);
  endtask

  // many hits on one bucket, then measures around it
  task automatic test_bucket_pileup();
    for (int i = 0; i < 60; i++) begin
      offer_beat(swhc_pkg::CMD_PUT, PILE_SEC);
      offer_beat(swhc_pkg::CMD_GET, PILE_SEC);
    end
    offer_beat(swhc_pkg::CMD_MEAS_PUT, PILE_SEC);
    offer_beat(swhc_pkg::CMD_MEAS_GET, PILE_SEC + 32'd10);
    offer_beat(swhc_pkg::CMD_PUT,      PILE_SEC);
    offer_beat(swhc_pkg::CMD_MEAS_PUT, PILE_SEC - 32'd100);
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_back_pressure();
    logic [swhc_pkg::STAMP_W-1:0] t;
    t = 32'd77_000;
    rx_hold_req = 400;
    for (int i = 0; i < 24; i++) begin
      offer_beat(swhc_pkg::cmd_t'($urandom_range(0, 1)), t);
      t = t + $urandom_range(0, 1);
    end
  endtask

  // random walk of seconds with jumps, mostly events, some measures
  task automatic test_random_traffic(int n_items, bit allow_idle);
    logic [swhc_pkg::STAMP_W-1:0] t;
    int                           r;
    swhc_pkg::cmd_t               c;
    t = $urandom();
    for (int i = 0; i < n_items; i++) begin
      // new idling mix every hundred beats
      if (i % 100 == 0) begin
        tx_stall_en = allow_idle && ($urandom_range(0, 3) != 0);
        rx_stall_en = allow_idle && ($urandom_range(0, 3) != 0);
      end
      r = $urandom_range(0, 99);
      if (r < 70)      t = t + $urandom_range(0, 2);
      else if (r < 82) t = t + $urandom_range(3, 40);
      else if (r < 88) t = t + $urandom_range(250, 700);
      else if (r < 93) t = t - $urandom_range(1, 350);
      else if (r < 96) t = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255)
                                                      : $urandom_range(0, 400);
      else             t = $urandom();
      if ($urandom_range(0, 99) < 12) c = swhc_pkg::cmd_t'($urandom_range(2, 3));
      else c = swhc_pkg::cmd_t'($urandom_range(0, 1));
      offer_beat(c, t);
    end
  endtask

  initial begin
    foreach (ring_stamp[k]) begin
      ring_stamp[k] = '0;
      ring_puts[k]  = '0;
      ring_gets[k]  = '0;
    end
    tx_stall_en = 1'b0;
    rx_stall_en = 1'b0;
    rx_hold_req = 0;
    errors      = 0;
    n_events    = 0;
    n_measures  = 0;
    n_checked   = 0;
    n_clamped   = 0;
    cycle_count = 0;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    cmd      <= swhc_pkg::CMD_PUT;
    now_sec  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed_edges();
    test_bucket_pileup();
    test_back_pressure();
    test_random_traffic(300, 1'b0);
    test_random_traffic(1300, 1'b1);

    // drain
    tx_stall_en = 1'b0;
    in_valid <= 1'b0;
    do @(posedge clk); while (owed_results.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d event beats and %0d measure beats, %0d results checked",
             n_events, n_measures, n_checked);
    $display("full-bucket increments held at limit: %0d, mismatches: %0d",
             n_clamped, errors);
    if (errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule
